>>> design/ccs_pkg.sv
package ccs_pkg;

	// character codes
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_NL    = 8'h0A;

	// scanner mode codes
	localparam logic [2:0] MODE_NORMAL    = 3'd0;
	localparam logic [2:0] MODE_SLASH     = 3'd1;
	localparam logic [2:0] MODE_LINE      = 3'd2;
	localparam logic [2:0] MODE_BLOCK     = 3'd3;
	localparam logic [2:0] MODE_BLOCKSTAR = 3'd4;

	// result queue depth and index widths
	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);
	localparam int QCW    = $clog2(QDEPTH + 1);

	// one result item
	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       run_last;
		logic       text_end;
	} res_t;

endpackage

>>> design/c_comment_stripper.sv
// C comment stripper, one text byte per request.
// Input channel s_axis: tdata = in_byte, tlast = text_last (final byte of a text).
// Output channel m_axis: tdata = out_byte, tuser = {run_last, byte_valid},
// tlast = text_end (final result of the whole text).
// Each input byte gives zero, one or two output results; a text's final byte
// always gives at least one (a bare end marker with byte_valid low if nothing
// else is kept there). Comment bytes give no result, but for that end marker.
// An accepted byte is registered in the input register, then processed into the
// result queue once the queue can take two results; its results show on m_axis
// from then on.
// Throughput: one input byte per cycle while the output is taken every cycle;
// a byte that gives two results adds an extra result, which the four-entry
// result queue absorbs until it holds more than two results, when input waits.
// Reset clears the input valid flag, empties the result queue, and clears the
// scanner mode and the newline flag; the next text starts in normal mode.
// When the receiver stalls, results pile up in the queue and s_axis_tready
// drops once it can no longer take two more results.
module c_comment_stripper
	import ccs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
	input  logic       s_axis_tlast,   // text_last
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,   // [7:0] out_byte
	output logic [1:0] m_axis_tuser,   // [0] byte_valid, [1] run_last
	output logic       m_axis_tlast    // text_end
);

	logic           valid_s1;
	logic [7:0]     byte_s1;
	logic           last_s1;
	logic [2:0]     mode_q;
	logic           nl_q;
	res_t           queue_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QCW-1:0] cnt_q;

	logic           advance;
	logic           pop;
	logic [2:0]     mode_d;
	logic           nl_d;
	logic [1:0]     n_res;
	res_t           em [2];

	// input register moves on when the queue can take two results
	assign advance       = valid_s1 && (cnt_q <= QCW'(QDEPTH - 2));
	assign s_axis_tready = !valid_s1 || advance;
	assign pop           = m_axis_tvalid && m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	// scanner: next mode, newline flag and up to two results
	always_comb begin
		mode_d = mode_q;
		nl_d   = nl_q;
		n_res  = 2'd0;
		em[0]  = '0;
		em[1]  = '0;
		case (mode_q)
			MODE_SLASH: begin
				mode_d = MODE_NORMAL;
				if (byte_s1 == CH_SLASH) begin
					mode_d = MODE_LINE;
				end else if (byte_s1 == CH_STAR) begin
					mode_d = MODE_BLOCK;
				end else begin
					// flush the held slash, then treat the byte as text
					em[0].out_byte   = CH_SLASH;
					em[0].byte_valid = 1'b1;
					n_res            = 2'd1;
					if (byte_s1 != CH_NL) begin
						em[1].out_byte   = byte_s1;
						em[1].byte_valid = 1'b1;
						n_res            = 2'd2;
					end else begin
						em[1].out_byte   = CH_NL;
						em[1].byte_valid = 1'b1;
						n_res            = 2'd2;
					end
					nl_d = (byte_s1 == CH_NL);
					if (byte_s1 == CH_SLASH && !last_s1) begin
						mode_d = MODE_SLASH;
					end
				end
			end
			MODE_LINE: begin
				if (byte_s1 == CH_NL) begin
					em[0].out_byte   = CH_NL;
					em[0].byte_valid = 1'b1;
					n_res            = 2'd1;
					mode_d           = MODE_NORMAL;
				end
			end
			MODE_BLOCK: begin
				if (byte_s1 == CH_STAR) begin
					mode_d = MODE_BLOCKSTAR;
				end
			end
			MODE_BLOCKSTAR: begin
				if (byte_s1 == CH_SLASH) begin
					mode_d = MODE_NORMAL;
				end else if (byte_s1 != CH_STAR) begin
					mode_d = MODE_BLOCK;
				end
			end
			default: begin
				mode_d = MODE_NORMAL;
				if (byte_s1 == CH_SLASH && !last_s1) begin
					mode_d = MODE_SLASH;
				end else begin
					// drop a newline that follows a kept newline
					if (byte_s1 != CH_NL || !nl_q) begin
						em[0].out_byte   = byte_s1;
						em[0].byte_valid = 1'b1;
						n_res            = 2'd1;
					end
					nl_d = (byte_s1 == CH_NL);
				end
			end
		endcase

		// end of text: bare marker if nothing kept, then back to reset state
		if (last_s1) begin
			if (n_res == 2'd0) begin
				em[0] = '0;
				n_res = 2'd1;
			end
			if (n_res == 2'd2) begin
				em[1].text_end = 1'b1;
			end else begin
				em[0].text_end = 1'b1;
			end
			mode_d = MODE_NORMAL;
			nl_d   = 1'b0;
		end

		// mark the last result of this byte
		if (n_res == 2'd2) begin
			em[1].run_last = 1'b1;
		end else if (n_res == 2'd1) begin
			em[0].run_last = 1'b1;
		end
	end

	// scanner state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_NORMAL;
			nl_q   <= 1'b0;
		end else if (advance) begin
			mode_q <= mode_d;
			nl_q   <= nl_d;
		end
	end

	// result queue storage
	always_ff @(posedge clk) begin
		if (advance && n_res != 2'd0) begin
			queue_q[wr_ptr_q] <= em[0];
		end
		if (advance && n_res == 2'd2) begin
			queue_q[wr_ptr_q + QAW'(1)] <= em[1];
		end
	end

	// result queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (advance) begin
				wr_ptr_q <= wr_ptr_q + QAW'(n_res);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QAW'(1);
			end
			cnt_q <= cnt_q + (advance ? QCW'(n_res) : QCW'(0)) - (pop ? QCW'(1) : QCW'(0));
		end
	end

	// output side
	assign m_axis_tvalid   = (cnt_q != '0);
	assign m_axis_tdata    = queue_q[rd_ptr_q].out_byte;
	assign m_axis_tuser[0] = queue_q[rd_ptr_q].byte_valid;
	assign m_axis_tuser[1] = queue_q[rd_ptr_q].run_last;
	assign m_axis_tlast    = queue_q[rd_ptr_q].text_end;

endmodule

>>> design/ccs_checker.sv
module ccs_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_axis_tvalid,
	input logic       s_axis_tready,
	input logic       m_axis_tvalid,
	input logic       m_axis_tready,
	input logic [7:0] m_axis_tdata,
	input logic [1:0] m_axis_tuser,
	input logic       m_axis_tlast
);

	// end of text is always the last result of its byte
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |-> m_axis_tuser[1])
		else $error("text end without run last");

	// a bare marker carries zero data and closes the text
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == 8'h00 && m_axis_tlast)
		else $error("bad bare end marker");

	// output becomes valid only after an accepted request has been registered and queued
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
		else $error("result without a request");

	// input is held off only while results are waiting
	assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid)
		else $error("input stalled with empty output");

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tuser) && $stable(m_axis_tlast))
		else $error("stalled result changed");

endmodule

bind c_comment_stripper ccs_checker u_ccs_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);

>>> test/c_comment_stripper_tb.sv
module c_comment_stripper_tb;
	import ccs_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASE_ITEMS = 130;
	localparam int HOLD_CYCLES = 300;

	// one row of the directed table; want is used only when typed is set
	typedef struct packed {
		logic [7:0] in_byte;
		logic       fin;
		logic       typed;
		res_t       want;
	} dir_row_t;

	localparam res_t NO_RES = '0;

	localparam dir_row_t DIR_TAB [26] = '{
		// single-byte texts: extremes and a trailing slash
		'{8'h00,    1'b1, 1'b1, {8'h00, 1'b1, 1'b1, 1'b1}},
		'{8'hFF,    1'b1, 1'b1, {8'hFF, 1'b1, 1'b1, 1'b1}},
		'{CH_SLASH, 1'b1, 1'b1, {CH_SLASH, 1'b1, 1'b1, 1'b1}},
		// "a//x\nb": line comment keeps its newline
		'{8'h61,    1'b0, 1'b0, NO_RES},
		'{CH_SLASH, 1'b0, 1'b0, NO_RES},
		'{CH_SLASH, 1'b0, 1'b0, NO_RES},
		'{8'h78,    1'b0, 1'b0, NO_RES},
		'{CH_NL,    1'b0, 1'b0, NO_RES},
		'{8'h62,    1'b1, 1'b0, NO_RES},
		// "/*a**/\n\n": block comment, then a repeated newline dropped
		'{CH_SLASH, 1'b0, 1'b0, NO_RES},
		'{CH_STAR,  1'b0, 1'b0, NO_RES},
		'{8'h61,    1'b0, 1'b0, NO_RES},
		'{CH_STAR,  1'b0, 1'b0, NO_RES},
		'{CH_STAR,  1'b0, 1'b0, NO_RES},
		'{CH_SLASH, 1'b0, 1'b0, NO_RES},
		'{CH_NL,    1'b0, 1'b0, NO_RES},
		'{CH_NL,    1'b1, 1'b0, NO_RES},
		// "/q": pending slash flushed, two results from one byte
		'{CH_SLASH, 1'b0, 1'b0, NO_RES},
		'{8'h71,    1'b1, 1'b0, NO_RES},
		// "/*z": unterminated comment, bare end marker
		'{CH_SLASH, 1'b0, 1'b0, NO_RES},
		'{CH_STAR,  1'b0, 1'b0, NO_RES},
		'{8'h7A,    1'b1, 1'b1, {8'h00, 1'b0, 1'b1, 1'b1}},
		// "\n//\n": closing newline of a line comment always kept
		'{CH_NL,    1'b0, 1'b0, NO_RES},
		'{CH_SLASH, 1'b0, 1'b0, NO_RES},
		'{CH_SLASH, 1'b0, 1'b0, NO_RES},
		'{CH_NL,    1'b1, 1'b0, NO_RES}
	};

	logic       clk;
	logic       arst_n;
	logic       s_axis_tvalid;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata;
	logic       s_axis_tlast;
	logic       m_axis_tvalid;
	logic       m_axis_tready;
	logic [7:0] m_axis_tdata;
	logic [1:0] m_axis_tuser;
	logic       m_axis_tlast;

	// scanner copy
	logic [2:0] scan_mode;
	logic       nl_seen;
	res_t       step_res [2];
	int         step_cnt;

	res_t       clean_q [$];
	logic [7:0] text_q [$];
	res_t       got_res;
	res_t       want_res;
	int         err_cnt = 0;
	int         cycle_cnt = 0;
	int         idle_pct = 0;
	int         stall_pct = 0;
	int         hold_left = 0;

	c_comment_stripper dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	// clock
	always #5 clk = ~clk;

	// byte seen in normal text with no slash pending
	function automatic void keep_plain(input logic [7:0] c, input logic fin);
		if (c == CH_SLASH && !fin) begin
			scan_mode = MODE_SLASH;
			return;
		end
		if (c != CH_NL || !nl_seen) begin
			step_res[step_cnt] = {c, 1'b1, 1'b0, 1'b0};
			step_cnt++;
		end
		nl_seen = (c == CH_NL);
	endfunction

	// results kept for one raw byte
	function automatic void strip_step(input logic [7:0] c, input logic fin);
		step_cnt = 0;
		step_res[0] = NO_RES;
		step_res[1] = NO_RES;
		case (scan_mode)
			MODE_SLASH: begin
				scan_mode = MODE_NORMAL;
				if (c == CH_SLASH) begin
					scan_mode = MODE_LINE;
				end else if (c == CH_STAR) begin
					scan_mode = MODE_BLOCK;
				end else begin
					step_res[0] = {CH_SLASH, 1'b1, 1'b0, 1'b0};
					step_cnt = 1;
					nl_seen = 1'b0;
					keep_plain(c, fin);
				end
			end
			MODE_LINE: begin
				if (c == CH_NL) begin
					step_res[0] = {CH_NL, 1'b1, 1'b0, 1'b0};
					step_cnt = 1;
					scan_mode = MODE_NORMAL;
				end
			end
			MODE_BLOCK: begin
				if (c == CH_STAR)
					scan_mode = MODE_BLOCKSTAR;
			end
			MODE_BLOCKSTAR: begin
				if (c == CH_SLASH)
					scan_mode = MODE_NORMAL;
				else if (c != CH_STAR)
					scan_mode = MODE_BLOCK;
			end
			default: begin
				scan_mode = MODE_NORMAL;
				keep_plain(c, fin);
			end
		endcase
		// end of text: bare marker if nothing kept, then back to reset state
		if (fin) begin
			if (step_cnt == 0)
				step_cnt = 1;
			step_res[step_cnt - 1].text_end = 1'b1;
			scan_mode = MODE_NORMAL;
			nl_seen = 1'b0;
		end
		if (step_cnt > 0)
			step_res[step_cnt - 1].run_last = 1'b1;
	endfunction

	// offer one byte, wait for acceptance, record what should come out
	task automatic send_byte(input logic [7:0] c, input logic fin, input logic typed,
			input res_t typed_res);
		@(negedge clk);
		while ($urandom_range(0, 99) < idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= c;
		s_axis_tlast  <= fin;
		do @(posedge clk); while (!s_axis_tready);
		strip_step(c, fin);
		if (typed) begin
			clean_q.push_back(typed_res);
		end else begin
			for (int k = 0; k < step_cnt; k++)
				clean_q.push_back(step_res[k]);
		end
	endtask

	// character mix that hits comment delimiters often
	function automatic logic [7:0] rand_char();
		case ($urandom_range(0, 9))
			0, 1: return CH_STAR;
			2: return CH_SLASH;
			3: return CH_NL;
			4: return 8'($urandom_range(0, 255));
			default: return 8'h61 + 8'($urandom_range(0, 25));
		endcase
	endfunction

	// random text made of words, comments, newlines and noise
	task automatic build_text();
		int pieces;
		int len;
		text_q.delete();
		pieces = $urandom_range(1, 6);
		repeat (pieces) begin
			len = $urandom_range(0, 6);
			case ($urandom_range(0, 9))
				0, 1: begin
					repeat (len + 1) text_q.push_back(8'h61 + 8'($urandom_range(0, 25)));
				end
				2, 3: begin
					text_q.push_back(CH_SLASH);
					text_q.push_back(CH_SLASH);
					repeat (len) text_q.push_back(rand_char());
					if ($urandom_range(0, 5) != 0)
						text_q.push_back(CH_NL);
				end
				4, 5: begin
					text_q.push_back(CH_SLASH);
					text_q.push_back(CH_STAR);
					repeat (len) text_q.push_back(rand_char());
					// occasionally left open
					if ($urandom_range(0, 5) != 0) begin
						text_q.push_back(CH_STAR);
						text_q.push_back(CH_SLASH);
					end
				end
				6: begin
					repeat ((len % 3) + 1) text_q.push_back(CH_NL);
				end
				7: text_q.push_back($urandom_range(0, 1) ? CH_SLASH : CH_STAR);
				8: text_q.push_back(8'h20);
				default: begin
					repeat (len + 1) text_q.push_back(8'($urandom_range(0, 255)));
				end
			endcase
		end
		if (text_q.size() == 0)
			text_q.push_back(rand_char());
	endtask

	// receiver: random stalls, or a long hold-off when requested
	always @(negedge clk) begin
		if (hold_left > 0) begin
			m_axis_tready <= 1'b0;
			hold_left <= hold_left - 1;
		end else begin
			m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	// result checker
	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready) begin
			got_res = {m_axis_tdata, m_axis_tuser[0], m_axis_tuser[1], m_axis_tlast};
			if (clean_q.size() == 0) begin
				err_cnt++;
				if (err_cnt <= 10)
					$display("unexpected result: byte %h valid %b run_last %b text_end %b",
						got_res.out_byte, got_res.byte_valid, got_res.run_last,
						got_res.text_end);
			end else begin
				want_res = clean_q.pop_front();
				if (got_res.out_byte !== want_res.out_byte ||
						got_res.byte_valid !== want_res.byte_valid ||
						got_res.run_last !== want_res.run_last ||
						got_res.text_end !== want_res.text_end) begin
					err_cnt++;
					if (err_cnt <= 10)
						$display({"mismatch: expected byte %h valid %b run_last %b ",
							"text_end %b, got byte %h valid %b run_last %b text_end %b"},
							want_res.out_byte, want_res.byte_valid, want_res.run_last,
							want_res.text_end, got_res.out_byte, got_res.byte_valid,
							got_res.run_last, got_res.text_end);
				end
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// stimulus
	initial begin
		int sent;
		clk = 1'b0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = 8'h00;
		s_axis_tlast = 1'b0;
		m_axis_tready = 1'b0;
		scan_mode = MODE_NORMAL;
		nl_seen = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed texts
		foreach (DIR_TAB[i])
			send_byte(DIR_TAB[i].in_byte, DIR_TAB[i].fin, DIR_TAB[i].typed,
				DIR_TAB[i].want);

		// random texts under each idling pattern, last phase with a long hold-off
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 71; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 71; end
				3: begin idle_pct = 21; stall_pct = 21; end
				default: begin
					idle_pct = 0;
					stall_pct = 0;
					hold_left = HOLD_CYCLES;
				end
			endcase
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				build_text();
				foreach (text_q[i])
					send_byte(text_q[i], i == text_q.size() - 1, 1'b0, NO_RES);
				sent += text_q.size();
			end
		end

		// drain
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (clean_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (err_cnt == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
